// ===== design/tccw_pkg.sv =====
// shared types and constants for the text console character writer
package tccw_pkg;

  localparam int unsigned COLS_DEF     = 80;
  localparam int unsigned ROWS_DEF     = 25;
  localparam int unsigned CONSOLES_DEF = 4;

  localparam int unsigned COL_FW  = 7;
  localparam int unsigned ROW_FW  = 5;
  localparam int unsigned CELL_W  = 16;
  localparam int unsigned ESCV_W  = 8;
  localparam int unsigned CHK_W   = 9;

  localparam logic [15:0] BLANK_RESET   = 16'h0F20;
  localparam logic [7:0]  COLOR_RESET   = 8'h0F;
  localparam logic [7:0]  CHR_BACKSPACE = 8'd127;
  localparam logic [7:0]  CHR_NEWLINE   = 8'd10;
  localparam logic [7:0]  CHR_SPACE     = 8'h20;

  typedef enum logic [1:0] {
    CMD_PUT  = 2'd0,
    CMD_ESC  = 2'd1,
    CMD_READ = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ESC_COLOR = 2'd0,
    ESC_COL   = 2'd1,
    ESC_ROW   = 2'd2,
    ESC_NONE  = 2'd3
  } esc_e;

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_EXEC  = 7'b0000100,
    ST_PRIME = 7'b0001000,
    ST_SHIFT = 7'b0010000,
    ST_RDATA = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_e;

endpackage

// ===== design/text_console_char_writer.sv =====
// Several text consoles share one cell memory. After reset the block sweeps the whole
// memory with the reset blank cell (BLANK_RESET), one entry a cycle, and takes no request
// meanwhile; blank_cell writes are taken at any time. One request is worked on at a time;
// a put character, an escape or a no-op is accepted, then executed, and its result goes
// straight to the output register when that is free; a read cell in range also passes the
// registered memory read first, and one out of range does not.
// A put character that scrolls primes a memory read, then moves rows 2 and on up one row
// through the single write port of the cell memory, one cell a cycle; row 0 stays and the
// last row is blanked with blank_cell. The output register lets the next request in while
// a result is stalled there; the next result then waits in the held result register.
module text_console_char_writer
  import tccw_pkg::*;
#(
  parameter int unsigned COLS     = COLS_DEF,
  parameter int unsigned ROWS     = ROWS_DEF,
  parameter int unsigned CONSOLES = CONSOLES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        cmd_i,
  input  logic [1:0]        console_i,
  input  logic [7:0]        chr_i,
  input  logic [1:0]        escape_code_i,
  input  logic [7:0]        escape_value_i,
  input  logic [6:0]        read_col_i,
  input  logic [4:0]        read_row_i,
  input  logic              active_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [6:0]        cursor_col_o,
  output logic [4:0]        cursor_row_o,
  output logic              cell_written_o,
  output logic [6:0]        cell_col_o,
  output logic [4:0]        cell_row_o,
  output logic [15:0]       cell_value_o,
  output logic              scrolled_o,
  output logic              redraw_o,
  output logic              cursor_moved_o
);

  localparam int unsigned MEM_DEPTH = CONSOLES * ROWS * COLS;
  localparam int unsigned AW  = $clog2(MEM_DEPTH);
  localparam int unsigned PW  = AW + 1;
  localparam int unsigned XW  = $clog2(COLS);
  localparam int unsigned YW  = $clog2(ROWS);
  localparam int unsigned CIW = (CONSOLES > 1) ? $clog2(CONSOLES) : 1;

  // control state
  state_e            state_q, state_d;
  logic [AW-1:0]     clr_ptr_q;
  logic              copy_q;
  logic [15:0]       blank_cell_q;
  logic [XW-1:0]     cur_col_q   [CONSOLES];
  logic [YW-1:0]     cur_row_q   [CONSOLES];
  logic [7:0]        cur_color_q [CONSOLES];

  // captured request
  cmd_e              cmd_q;
  logic [1:0]        cons_q;
  logic [7:0]        chr_q;
  esc_e              ecode_q;
  logic [7:0]        evalue_q;
  logic [6:0]        rcol_q;
  logic [4:0]        rrow_q;
  logic              active_q;

  // scroll pointers
  logic [PW-1:0]     rd_ptr_q, wr_ptr_q, end_ptr_q;

  // held result
  logic [6:0]        res_col_q, res_ccol_q;
  logic [4:0]        res_row_q, res_crow_q;
  logic              res_wr_q, res_scroll_q, res_redraw_q, res_moved_q;
  logic [15:0]       res_val_q;

  // output register
  logic              out_valid_q;
  logic [6:0]        out_col_q, out_ccol_q;
  logic [4:0]        out_row_q, out_crow_q;
  logic              out_wr_q, out_scroll_q, out_redraw_q, out_moved_q;
  logic [15:0]       out_val_q;

  // cell memory
  logic [15:0]       mem [MEM_DEPTH];
  logic [15:0]       mem_rd_q;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [15:0]       mem_wdata;

  // execute datapath
  logic [CIW-1:0]    cidx;
  logic              cons_ok;
  logic [XW-1:0]     cur_x, nx, bx, wx;
  logic [YW-1:0]     cur_y, ny, by, wy;
  logic [7:0]        cur_color, ncolor;
  logic [XW:0]       x_inc;
  logic [YW:0]       y_inc, y_nxt;
  logic [CHK_W-1:0]  px, py;
  logic              wr_cell, do_scroll, upd, rd_req, rd_ok;
  logic              r_redraw, r_moved;
  logic [15:0]       wval;
  logic [AW-1:0]     base, cell_addr, ax, ay;
  logic [6:0]        r_col, r_ccol;
  logic [4:0]        r_row, r_crow;
  logic              out_free, fast_done, ld_out, ld_from_exec, accept;

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  assign cidx      = CIW'(cons_q);
  assign cons_ok   = (5'(cons_q) < 5'(CONSOLES));
  assign cur_x     = cur_col_q[cidx];
  assign cur_y     = cur_row_q[cidx];
  assign cur_color = cur_color_q[cidx];
  assign x_inc     = {1'b0, cur_x} + 1'b1;
  assign y_inc     = {1'b0, cur_y} + 1'b1;
  assign rd_ok     = (CHK_W'(rcol_q) < CHK_W'(COLS)) && (CHK_W'(rrow_q) < CHK_W'(ROWS));

  always_comb begin
    nx        = cur_x;
    ny        = cur_y;
    ncolor    = cur_color;
    bx        = cur_x;
    by        = cur_y;
    wx        = cur_x;
    wy        = cur_y;
    y_nxt     = {1'b0, cur_y};
    px        = CHK_W'(cur_x);
    py        = CHK_W'(cur_y);
    wr_cell   = 1'b0;
    wval      = '0;
    do_scroll = 1'b0;
    upd       = 1'b0;
    rd_req    = 1'b0;
    r_redraw  = 1'b0;
    r_moved   = 1'b0;
    if (cons_ok) begin
      unique case (cmd_q)
        CMD_PUT: begin
          upd     = 1'b1;
          r_moved = active_q;
          if (chr_q == CHR_BACKSPACE) begin
            if (cur_x == '0) begin
              bx = XW'(COLS - 1);
              by = (cur_y != '0) ? cur_y - 1'b1 : '0;
            end else begin
              bx = cur_x - 1'b1;
            end
            if (by == '0) begin
              by = YW'(1);
            end
            wr_cell  = 1'b1;
            wx       = bx;
            wy       = by;
            wval     = {cur_color, CHR_SPACE};
            nx       = bx;
            ny       = by;
            r_redraw = active_q;
          end else begin
            if (chr_q != CHR_NEWLINE) begin
              wr_cell = 1'b1;
              wval    = {cur_color, chr_q};
              if (x_inc >= (XW + 1)'(COLS)) begin
                nx    = '0;
                y_nxt = y_inc;
              end else begin
                nx = XW'(x_inc);
              end
            end else begin
              nx    = '0;
              y_nxt = y_inc;
            end
            // past the last row: scroll and stay on the last row
            if (y_nxt >= (YW + 1)'(ROWS)) begin
              ny        = YW'(ROWS - 1);
              do_scroll = 1'b1;
              r_redraw  = active_q;
            end else begin
              ny = YW'(y_nxt);
            end
          end
        end
        CMD_ESC: begin
          unique case (ecode_q)
            ESC_COLOR: begin
              ncolor = evalue_q;
              upd    = 1'b1;
            end
            ESC_COL, ESC_ROW: begin
              if (ecode_q == ESC_COL) begin
                px = CHK_W'(evalue_q);
              end else begin
                py = CHK_W'(evalue_q) + 1'b1;
              end
              if ((px < CHK_W'(COLS)) && (py < CHK_W'(ROWS))) begin
                nx      = XW'(px);
                ny      = YW'(py);
                upd     = 1'b1;
                r_moved = active_q;
              end
            end
            default: begin
            end
          endcase
        end
        CMD_READ: begin
          rd_req = rd_ok;
        end
        default: begin
        end
      endcase
    end
  end

  assign r_col  = cons_ok ? 7'(nx) : '0;
  assign r_row  = cons_ok ? 5'(ny) : '0;
  assign r_ccol = (cons_ok && (cmd_q == CMD_READ)) ? rcol_q : (wr_cell ? 7'(wx) : '0);
  assign r_crow = (cons_ok && (cmd_q == CMD_READ)) ? rrow_q : (wr_cell ? 5'(wy) : '0);

  // linear cell address: (console * ROWS + row) * COLS + col
  assign ax        = rd_req ? AW'(rcol_q) : AW'(wx);
  assign ay        = rd_req ? AW'(rrow_q) : AW'(wy);
  assign base      = AW'(cidx) * AW'(ROWS * COLS);
  assign cell_addr = base + ay * AW'(COLS) + ax;

  assign fast_done    = (state_q == ST_EXEC) && !do_scroll && !rd_req && out_free;
  assign ld_from_exec = (state_q == ST_EXEC);
  assign ld_out       = fast_done || ((state_q == ST_OUT) && out_free);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_ptr_q == AW'(MEM_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (do_scroll) begin
          state_d = ST_PRIME;
        end else if (rd_req) begin
          state_d = ST_RDATA;
        end else if (out_free) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_PRIME: begin
        state_d = ST_SHIFT;
      end
      ST_SHIFT: begin
        if (wr_ptr_q == end_ptr_q - 1'b1) begin
          state_d = ST_OUT;
        end
      end
      ST_RDATA: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cell_addr;
    mem_wdata = wval;
    mem_re    = 1'b0;
    mem_raddr = cell_addr;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_ptr_q;
        mem_wdata = BLANK_RESET;
      end
      ST_EXEC: begin
        mem_we = wr_cell;
        mem_re = rd_req;
      end
      ST_PRIME: begin
        mem_re    = 1'b1;
        mem_raddr = rd_ptr_q[AW-1:0];
      end
      ST_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = wr_ptr_q[AW-1:0];
        mem_wdata = copy_q ? mem_rd_q : blank_cell_q;
        mem_re    = (rd_ptr_q != end_ptr_q);
        mem_raddr = rd_ptr_q[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rd_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_ptr_q    <= '0;
      copy_q       <= 1'b0;
      blank_cell_q <= BLANK_RESET;
      for (int i = 0; i < CONSOLES; i++) begin
        cur_col_q[i]   <= '0;
        cur_row_q[i]   <= YW'(1);
        cur_color_q[i] <= COLOR_RESET;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        blank_cell_q <= cfg_wdata_i;
      end
      if (state_q == ST_CLEAR) begin
        clr_ptr_q <= clr_ptr_q + 1'b1;
      end
      if ((state_q == ST_EXEC) && cons_ok && upd) begin
        cur_col_q[cidx]   <= nx;
        cur_row_q[cidx]   <= ny;
        cur_color_q[cidx] <= ncolor;
      end
      if (state_q == ST_PRIME) begin
        copy_q <= 1'b1;
      end else if (state_q == ST_SHIFT) begin
        copy_q <= (rd_ptr_q != end_ptr_q);
      end
    end
  end

  // request capture, scroll pointers and held result
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q    <= cmd_e'(cmd_i);
      cons_q   <= console_i;
      chr_q    <= chr_i;
      ecode_q  <= esc_e'(escape_code_i);
      evalue_q <= escape_value_i;
      rcol_q   <= read_col_i;
      rrow_q   <= read_row_i;
      active_q <= active_i;
    end
    if (state_q == ST_EXEC) begin
      rd_ptr_q     <= PW'(base) + PW'(2 * COLS);
      wr_ptr_q     <= PW'(base) + PW'(COLS);
      end_ptr_q    <= PW'(base) + PW'(ROWS * COLS);
      res_col_q    <= r_col;
      res_row_q    <= r_row;
      res_wr_q     <= wr_cell;
      res_ccol_q   <= r_ccol;
      res_crow_q   <= r_crow;
      res_val_q    <= wval;
      res_scroll_q <= do_scroll;
      res_redraw_q <= r_redraw;
      res_moved_q  <= r_moved;
    end
    if (state_q == ST_PRIME) begin
      rd_ptr_q <= rd_ptr_q + 1'b1;
    end
    if (state_q == ST_SHIFT) begin
      wr_ptr_q <= wr_ptr_q + 1'b1;
      if (rd_ptr_q != end_ptr_q) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
    if (state_q == ST_RDATA) begin
      res_val_q <= mem_rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ld_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_out) begin
      if (ld_from_exec) begin
        out_col_q    <= r_col;
        out_row_q    <= r_row;
        out_wr_q     <= wr_cell;
        out_ccol_q   <= r_ccol;
        out_crow_q   <= r_crow;
        out_val_q    <= wval;
        out_scroll_q <= do_scroll;
        out_redraw_q <= r_redraw;
        out_moved_q  <= r_moved;
      end else begin
        out_col_q    <= res_col_q;
        out_row_q    <= res_row_q;
        out_wr_q     <= res_wr_q;
        out_ccol_q   <= res_ccol_q;
        out_crow_q   <= res_crow_q;
        out_val_q    <= res_val_q;
        out_scroll_q <= res_scroll_q;
        out_redraw_q <= res_redraw_q;
        out_moved_q  <= res_moved_q;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign cursor_col_o   = out_col_q;
  assign cursor_row_o   = out_row_q;
  assign cell_written_o = out_wr_q;
  assign cell_col_o     = out_ccol_q;
  assign cell_row_o     = out_crow_q;
  assign cell_value_o   = out_val_q;
  assign scrolled_o     = out_scroll_q;
  assign redraw_o       = out_redraw_q;
  assign cursor_moved_o = out_moved_q;

endmodule

// ===== tb/text_console_char_writer_test.sv =====
// testbench for the text console character writer: directed and random requests, predicted and checked
`timescale 1ns / 1ps

module text_console_char_writer_test;
  import tccw_pkg::*;

  typedef struct packed {
    cmd_e        cmd;
    logic [1:0]  console;
    logic [7:0]  chr;
    esc_e        ecode;
    logic [7:0]  eval;
    logic [6:0]  rcol;
    logic [4:0]  rrow;
    logic        act;
  } req_t;

  typedef struct packed {
    logic [6:0]  cur_col;
    logic [4:0]  cur_row;
    logic        written;
    logic [6:0]  cell_col;
    logic [4:0]  cell_row;
    logic [15:0] cell_val;
    logic        scrolled;
    logic        redraw;
    logic        moved;
  } res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [6:0]  cursor_col_o;
  logic [4:0]  cursor_row_o;
  logic        cell_written_o;
  logic [6:0]  cell_col_o;
  logic [4:0]  cell_row_o;
  logic [15:0] cell_value_o;
  logic        scrolled_o;
  logic        redraw_o;
  logic        cursor_moved_o;

  req_t        drv_req = '0;
  req_t        req_q[$];
  res_t        exp_res_q[$];
  bit          req_taken = 1'b0;
  bit          calm = 1'b0;
  int          err_cnt = 0;
  res_t        got, want, next_res;

  // console state as the block should hold it
  logic [15:0] scr_mem[CONSOLES_DEF][ROWS_DEF][COLS_DEF];
  int unsigned cur_x[CONSOLES_DEF];
  int unsigned cur_y[CONSOLES_DEF];
  logic [7:0]  ink[CONSOLES_DEF];
  logic [15:0] blank_q = BLANK_RESET;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  text_console_char_writer i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (drv_req.cmd),
    .console_i      (drv_req.console),
    .chr_i          (drv_req.chr),
    .escape_code_i  (drv_req.ecode),
    .escape_value_i (drv_req.eval),
    .read_col_i     (drv_req.rcol),
    .read_row_i     (drv_req.rrow),
    .active_i       (drv_req.act),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .cursor_col_o   (cursor_col_o),
    .cursor_row_o   (cursor_row_o),
    .cell_written_o (cell_written_o),
    .cell_col_o     (cell_col_o),
    .cell_row_o     (cell_row_o),
    .cell_value_o   (cell_value_o),
    .scrolled_o     (scrolled_o),
    .redraw_o       (redraw_o),
    .cursor_moved_o (cursor_moved_o)
  );

  task automatic console_step(input req_t r, output res_t e);
    int unsigned c, x, y, px, py;
    begin
      e = '0;
      c = r.console;
      x = cur_x[c];
      y = cur_y[c];
      case (r.cmd)
        CMD_PUT: begin
          if (r.chr == CHR_BACKSPACE) begin
            if (x == 0) begin
              x = COLS_DEF - 1;
              if (y > 0) y--;
            end else begin
              x--;
            end
            if (y < 1) y = 1;
            e.cell_val = {ink[c], CHR_SPACE};
            scr_mem[c][y][x] = e.cell_val;
            e.written = 1'b1;
            e.cell_col = 7'(x);
            e.cell_row = 5'(y);
            e.redraw = r.act;
          end else begin
            if (r.chr != CHR_NEWLINE) begin
              e.cell_val = {ink[c], r.chr};
              scr_mem[c][y][x] = e.cell_val;
              e.written = 1'b1;
              e.cell_col = 7'(x);
              e.cell_row = 5'(y);
              x++;
            end else begin
              y++;
              x = 0;
            end
            if (x >= COLS_DEF) begin
              x = 0;
              y++;
            end
            if (y >= ROWS_DEF) begin
              y = ROWS_DEF - 1;
              // header row stays, rows 2.. move up, bottom row gets the blank cell
              for (int yy = 2; yy < ROWS_DEF; yy++)
                for (int xx = 0; xx < COLS_DEF; xx++)
                  scr_mem[c][yy-1][xx] = scr_mem[c][yy][xx];
              for (int xx = 0; xx < COLS_DEF; xx++)
                scr_mem[c][ROWS_DEF-1][xx] = blank_q;
              e.scrolled = 1'b1;
              e.redraw = r.act;
            end
          end
          cur_x[c] = x;
          cur_y[c] = y;
          e.moved = r.act;
        end
        CMD_ESC: begin
          if (r.ecode == ESC_COLOR) begin
            ink[c] = r.eval;
          end else if (r.ecode == ESC_COL || r.ecode == ESC_ROW) begin
            px = x;
            py = y;
            if (r.ecode == ESC_COL) px = 32'(r.eval);
            else py = 32'(r.eval) + 32'd1;
            if (px < COLS_DEF && py < ROWS_DEF) begin
              cur_x[c] = px;
              cur_y[c] = py;
              e.moved = r.act;
            end
          end
        end
        CMD_READ: begin
          e.cell_col = r.rcol;
          e.cell_row = r.rrow;
          if (r.rcol < COLS_DEF && r.rrow < ROWS_DEF)
            e.cell_val = scr_mem[c][r.rrow][r.rcol];
        end
        default: ;
      endcase
      e.cur_col = 7'(cur_x[c]);
      e.cur_row = 5'(cur_y[c]);
    end
  endtask

  function automatic string res_str(input res_t v);
    return $sformatf("cur=(%0d,%0d) wr=%0b cell=(%0d,%0d) val=%h scr=%0b rdw=%0b mov=%0b",
                     v.cur_col, v.cur_row, v.written, v.cell_col, v.cell_row, v.cell_val,
                     v.scrolled, v.redraw, v.moved);
  endfunction

  // mostly text with random content, some control bytes, escapes and reads
  function automatic req_t rand_item();
    req_t r;
    int unsigned k;
    r.cmd     = cmd_e'($urandom_range(0, 3));
    r.console = 2'($urandom);
    r.chr     = 8'($urandom);
    r.ecode   = esc_e'($urandom_range(0, 3));
    r.eval    = 8'($urandom);
    r.rcol    = 7'($urandom);
    r.rrow    = 5'($urandom);
    r.act     = 1'($urandom);
    k = $urandom_range(0, 99);
    if (k < 50) begin
      r.cmd = CMD_PUT;
      r.chr = 8'($urandom_range(32, 126));
    end else if (k < 58) begin
      r.cmd = CMD_PUT;
    end else if (k < 63) begin
      r.cmd = CMD_PUT;
      r.chr = CHR_NEWLINE;
    end else if (k < 68) begin
      r.cmd = CMD_PUT;
      r.chr = CHR_BACKSPACE;
    end else if (k < 78) begin
      r.cmd = CMD_ESC;
      if ($urandom_range(0, 3) != 0) begin
        case (r.ecode)
          ESC_COL: r.eval = 8'($urandom_range(0, COLS_DEF - 1));
          ESC_ROW: r.eval = 8'($urandom_range(0, ROWS_DEF - 2));
          default: ;
        endcase
      end
    end else if (k < 97) begin
      r.cmd = CMD_READ;
      if ($urandom_range(0, 9) != 0) begin
        r.rcol = 7'($urandom_range(0, COLS_DEF - 1));
        // bottom rows see the most traffic once consoles start scrolling
        if ($urandom_range(0, 1) != 0) r.rrow = 5'($urandom_range(ROWS_DEF - 3, ROWS_DEF - 1));
        else r.rrow = 5'($urandom_range(0, ROWS_DEF - 1));
      end
    end else begin
      r.cmd = CMD_NOP;
    end
    return r;
  endfunction

  task automatic add_req(input cmd_e c, input logic [1:0] con, input logic [7:0] b,
                         input esc_e e, input logic [6:0] col, input logic [4:0] row,
                         input logic act);
    req_t r;
    r = rand_item();
    r.cmd = c;
    r.console = con;
    r.act = act;
    case (c)
      CMD_PUT: r.chr = b;
      CMD_ESC: begin
        r.ecode = e;
        r.eval = b;
      end
      CMD_READ: begin
        r.rcol = col;
        r.rrow = row;
      end
      default: ;
    endcase
    req_q.push_back(r);
  endtask

  task automatic add_random(input int n);
    repeat (n) req_q.push_back(rand_item());
  endtask

  task automatic wait_drained();
    while (req_q.size() != 0 || in_valid_i || exp_res_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_blank(input logic [15:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    blank_q = v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // request driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || req_taken) begin
        req_taken = 1'b0;
        if (req_q.size() != 0 && (calm || $urandom_range(0, 99) >= 18)) begin
          drv_req <= req_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= !calm && ($urandom_range(0, 99) < 18);
    end
  end

  // result check first, then prediction of the request taken at this edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = {cursor_col_o, cursor_row_o, cell_written_o, cell_col_o, cell_row_o,
               cell_value_o, scrolled_o, redraw_o, cursor_moved_o};
        if (exp_res_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) $display("unexpected result: %s", res_str(got));
        end else begin
          want = exp_res_q.pop_front();
          if (got !== want) begin
            err_cnt++;
            if (err_cnt <= 10) begin
              $display("mismatch at %0t", $realtime);
              $display("  expected %s", res_str(want));
              $display("  actual   %s", res_str(got));
            end
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        console_step(drv_req, next_res);
        exp_res_q.push_back(next_res);
        req_taken = 1'b1;
      end
    end
  end

  initial begin
    for (int c = 0; c < CONSOLES_DEF; c++) begin
      cur_x[c] = 0;
      cur_y[c] = 1;
      ink[c] = COLOR_RESET;
      for (int y = 0; y < ROWS_DEF; y++)
        for (int x = 0; x < COLS_DEF; x++)
          scr_mem[c][y][x] = BLANK_RESET;
    end
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    add_req(CMD_READ, 0, 0, ESC_NONE, 0, 0, 1);
    add_req(CMD_PUT, 0, 8'h41, ESC_NONE, 0, 0, 1);
    add_req(CMD_PUT, 0, 8'h00, ESC_NONE, 0, 0, 0);
    add_req(CMD_PUT, 0, 8'hFF, ESC_NONE, 0, 0, 1);
    add_req(CMD_PUT, 0, CHR_BACKSPACE, ESC_NONE, 0, 0, 1);
    // backspace from the first text row wraps and clamps to row 1
    add_req(CMD_PUT, 1, CHR_BACKSPACE, ESC_NONE, 0, 0, 1);
    add_req(CMD_ESC, 1, 8'hFF, ESC_COLOR, 0, 0, 1);
    add_req(CMD_PUT, 1, 8'h7A, ESC_NONE, 0, 0, 1);
    add_req(CMD_ESC, 1, 8'h00, ESC_COLOR, 0, 0, 1);
    add_req(CMD_ESC, 2, 8'd79, ESC_COL, 0, 0, 1);
    add_req(CMD_ESC, 2, 8'd80, ESC_COL, 0, 0, 1);
    add_req(CMD_ESC, 2, 8'd255, ESC_COL, 0, 0, 1);
    add_req(CMD_ESC, 2, 8'd23, ESC_ROW, 0, 0, 1);
    add_req(CMD_ESC, 2, 8'd24, ESC_ROW, 0, 0, 1);
    add_req(CMD_ESC, 2, 8'd255, ESC_ROW, 0, 0, 0);
    // last cell of the screen: write, wrap and scroll in one request
    add_req(CMD_PUT, 2, 8'h51, ESC_NONE, 0, 0, 1);
    add_req(CMD_PUT, 2, CHR_NEWLINE, ESC_NONE, 0, 0, 1);
    add_req(CMD_PUT, 3, CHR_NEWLINE, ESC_NONE, 0, 0, 0);
    add_req(CMD_ESC, 3, 8'hAA, ESC_NONE, 0, 0, 1);
    add_req(CMD_READ, 2, 0, ESC_NONE, 7'd79, 5'd22, 1);
    add_req(CMD_READ, 1, 0, ESC_NONE, 7'd127, 5'd31, 1);
    add_req(CMD_READ, 1, 0, ESC_NONE, 7'd80, 5'd0, 0);
    add_req(CMD_READ, 1, 0, ESC_NONE, 7'd0, 5'd25, 1);
    add_req(CMD_NOP, 0, 0, ESC_NONE, 0, 0, 1);
    add_req(CMD_ESC, 3, 8'd4, ESC_ROW, 0, 0, 1);
    add_req(CMD_ESC, 3, 8'd0, ESC_COL, 0, 0, 1);
    add_req(CMD_PUT, 3, CHR_BACKSPACE, ESC_NONE, 0, 0, 0);
    wait_drained();

    write_blank(16'h0000);
    add_random(660);
    wait_drained();

    write_blank(16'hFFFF);
    calm = 1'b1;
    add_random(660);
    wait_drained();
    calm = 1'b0;

    write_blank(16'($urandom));
    add_random(680);
    wait_drained();

    repeat (20) @(posedge clk_i);
    if (err_cnt == 0 && exp_res_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
